@@ rtl/core/nnc3d_pkg.sv @@
package nnc3d_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int COORD_BITS_DEF  = 16;

    localparam int OP_W       = 2;
    localparam int LABEL_W    = 3;
    localparam int INDEX_W    = 8;
    localparam int DIST_OUT_W = 36;
    localparam int AXIS_W     = 2;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [AXIS_W-1:0] AX_X = 2'd0;
    localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AX_Z = 2'd2;

    localparam logic [LABEL_W-1:0] LABEL_MIN   = 3'd1;
    localparam logic [LABEL_W-1:0] LABEL_MAX   = 3'd5;
    localparam logic [LABEL_W-1:0] LABEL_OTHER = 3'd6;

    function automatic logic [LABEL_W-1:0] map_label(input logic [LABEL_W-1:0] lab);
        logic [LABEL_W-1:0] res;
        if (lab < LABEL_MIN || lab > LABEL_MAX)
            res = LABEL_OTHER;
        else
            res = lab;
        return res;
    endfunction

endpackage

@@ rtl/core/nearest_neighbour_classifier_3d.sv @@
// Nearest neighbour classifier over a store of labelled 3D points.
// Input channel (item_valid/item_ready) carries an operation with x, y, z
// and a label: clear empties the store, load appends a point (ignored when
// the store is full), query returns the label of the closest stored point
// by squared distance, lowest index on ties. Output channel
// (result_valid/result_ready) carries one result per query only.
// Clear and load complete in the transfer cycle; the block stays ready.
// A query reads the stored points from memory in index order; one squarer
// is shared over the three axes, so each point passes through it one axis
// at a time, and the pipeline drains after the last point. An empty store
// skips the scan and goes straight to the done state. item_ready is low
// from a query transfer until its result is in the output register.
// If the receiver stalls, the result waits in the output register and
// clear or load items are still taken; a following query holds its result
// until the previous one is taken.
// Reset empties the store and clears all handshake state; the memory
// contents are not cleared and unwritten entries never reach a result.
module nearest_neighbour_classifier_3d #(
    parameter int STORE_DEPTH = nnc3d_pkg::STORE_DEPTH_DEF,
    parameter int COORD_BITS  = nnc3d_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [nnc3d_pkg::OP_W-1:0]         operation,
    input  logic signed [COORD_BITS-1:0]       coord_x,
    input  logic signed [COORD_BITS-1:0]       coord_y,
    input  logic signed [COORD_BITS-1:0]       coord_z,
    input  logic [nnc3d_pkg::LABEL_W-1:0]      train_label,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [nnc3d_pkg::LABEL_W-1:0]      predicted_label,
    output logic [nnc3d_pkg::INDEX_W-1:0]      nearest_index,
    output logic [nnc3d_pkg::DIST_OUT_W-1:0]   min_distance_sq,
    output logic                               empty_store
);
    import nnc3d_pkg::*;

    localparam int IDX_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = SQ_W + 2;
    localparam int ENTRY_W = 3 * COORD_BITS + LABEL_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      pt_reg, pt_next;
    logic [AXIS_W-1:0]     ax_reg, ax_next;
    logic [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic                  empty_reg;

    logic [ENTRY_W-1:0]    store_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0]    rd_reg;
    logic                  mem_we;
    logic                  item_xfer;
    logic                  last_issue;

    logic                  s1_v_reg;
    logic [AXIS_W-1:0]     s1_ax_reg;
    logic [IDX_W-1:0]      s1_idx_reg;

    logic                  s2_v_reg;
    logic [AXIS_W-1:0]     s2_ax_reg;
    logic [IDX_W-1:0]      s2_idx_reg;
    logic [LABEL_W-1:0]    s2_lab_reg;
    logic [COORD_BITS-1:0] s2_mag_reg;

    logic                  s3_v_reg;
    logic [AXIS_W-1:0]     s3_ax_reg;
    logic [IDX_W-1:0]      s3_idx_reg;
    logic [LABEL_W-1:0]    s3_lab_reg;
    logic [SQ_W-1:0]       s3_sq_reg;

    logic [DIST_W-1:0]     acc_reg;
    logic [DIST_W-1:0]     acc_sum;
    logic                  dist_v_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [IDX_W-1:0]      dist_idx_reg;
    logic [LABEL_W-1:0]    dist_lab_reg;

    logic [DIST_W-1:0]     best_dist_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [LABEL_W-1:0]    best_lab_reg;

    logic [COORD_BITS-1:0] sel_t, sel_q;
    logic [COORD_BITS:0]   diff, diff_neg;
    logic [COORD_BITS-1:0] mag;

    logic                  res_v_reg;
    logic [LABEL_W-1:0]    res_lab_reg;
    logic [INDEX_W-1:0]    res_idx_reg;
    logic [DIST_OUT_W-1:0] res_dist_reg;
    logic                  res_empty_reg;
    logic                  res_load;

    logic [IDX_W+INDEX_W-1:0]      idx_ext;
    logic [DIST_W+DIST_OUT_W-1:0]  dist_ext;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_xfer  = item_valid && item_ready;
    assign mem_we     = item_xfer && (operation == OP_LOAD)
                        && (count_reg < CNT_W'(STORE_DEPTH));
    assign last_issue = (ax_reg == AX_Z)
                        && (CNT_W'(pt_reg) == count_reg - CNT_W'(1));
    assign res_load   = (state_reg == ST_DONE) && (!res_v_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pt_next    = pt_reg;
        ax_next    = ax_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    unique case (operation)
                        OP_CLEAR:
                            count_next = '0;
                        OP_LOAD:
                        begin
                            if (mem_we)
                                count_next = count_reg + CNT_W'(1);
                        end
                        OP_QUERY:
                        begin
                            pt_next = '0;
                            ax_next = AX_X;
                            if (count_reg == '0)
                                state_next = ST_DONE;
                            else
                                state_next = ST_SCAN;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (ax_reg == AX_Z)
                begin
                    ax_next = AX_X;
                    pt_next = pt_reg + IDX_W'(1);
                    if (last_issue)
                        state_next = ST_DRAIN;
                end
                else
                begin
                    ax_next = ax_reg + AXIS_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!(s1_v_reg || s2_v_reg || s3_v_reg || dist_v_reg))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pt_reg    <= '0;
            ax_reg    <= AX_X;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pt_reg    <= pt_next;
            ax_reg    <= ax_next;
        end
    end

    // point store: {label, z, y, x}
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[count_reg[IDX_W-1:0]] <= {train_label, coord_z, coord_y, coord_x};
        rd_reg <= store_mem[pt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer && (operation == OP_QUERY))
        begin
            qx_reg    <= coord_x;
            qy_reg    <= coord_y;
            qz_reg    <= coord_z;
            empty_reg <= (count_reg == '0);
        end
    end

    always_comb
    begin
        case (s1_ax_reg)
            AX_X:
            begin
                sel_t = rd_reg[COORD_BITS-1:0];
                sel_q = qx_reg;
            end
            AX_Y:
            begin
                sel_t = rd_reg[2*COORD_BITS-1:COORD_BITS];
                sel_q = qy_reg;
            end
            default:
            begin
                sel_t = rd_reg[3*COORD_BITS-1:2*COORD_BITS];
                sel_q = qz_reg;
            end
        endcase
    end

    assign diff     = {sel_t[COORD_BITS-1], sel_t} - {sel_q[COORD_BITS-1], sel_q};
    assign diff_neg = -diff;
    assign mag      = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
    assign acc_sum  = acc_reg + {2'b00, s3_sq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            dist_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg   <= (state_reg == ST_SCAN);
            s2_v_reg   <= s1_v_reg;
            s3_v_reg   <= s2_v_reg;
            dist_v_reg <= s3_v_reg && (s3_ax_reg == AX_Z);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ax_reg  <= ax_reg;
        s1_idx_reg <= pt_reg;

        s2_ax_reg  <= s1_ax_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_lab_reg <= rd_reg[ENTRY_W-1:3*COORD_BITS];
        s2_mag_reg <= mag;

        s3_ax_reg  <= s2_ax_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_lab_reg <= s2_lab_reg;
        s3_sq_reg  <= {{COORD_BITS{1'b0}}, s2_mag_reg} * {{COORD_BITS{1'b0}}, s2_mag_reg};

        if (s3_v_reg)
        begin
            if (s3_ax_reg == AX_X)
                acc_reg <= {2'b00, s3_sq_reg};
            else
                acc_reg <= acc_sum;
        end
        dist_reg     <= acc_sum;
        dist_idx_reg <= s3_idx_reg;
        dist_lab_reg <= s3_lab_reg;

        if (item_xfer && (operation == OP_QUERY))
        begin
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            best_lab_reg  <= LABEL_OTHER;
        end
        else if (dist_v_reg && ((dist_idx_reg == '0) || (dist_reg < best_dist_reg)))
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= dist_idx_reg;
            best_lab_reg  <= dist_lab_reg;
        end
    end

    assign idx_ext  = {{INDEX_W{1'b0}}, best_idx_reg};
    assign dist_ext = {{DIST_OUT_W{1'b0}}, best_dist_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_v_reg <= 1'b0;
        else if (res_load)
            res_v_reg <= 1'b1;
        else if (result_ready)
            res_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_lab_reg   <= empty_reg ? LABEL_OTHER : map_label(best_lab_reg);
            res_idx_reg   <= idx_ext[INDEX_W-1:0];
            res_dist_reg  <= dist_ext[DIST_OUT_W-1:0];
            res_empty_reg <= empty_reg;
        end
    end

    assign result_valid    = res_v_reg;
    assign predicted_label = res_lab_reg;
    assign nearest_index   = res_idx_reg;
    assign min_distance_sq = res_dist_reg;
    assign empty_store     = res_empty_reg;

endmodule

@@ rtl/core/nnc3d_checker.sv @@
module nnc3d_assertions (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input logic [nnc3d_pkg::OP_W-1:0]         operation,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic [nnc3d_pkg::LABEL_W-1:0]      predicted_label,
    input logic [nnc3d_pkg::INDEX_W-1:0]      nearest_index,
    input logic [nnc3d_pkg::DIST_OUT_W-1:0]   min_distance_sq,
    input logic                               empty_store
);
    import nnc3d_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(predicted_label)
            && $stable(nearest_index) && $stable(min_distance_sq) && $stable(empty_store))
        else $error("result changed while stalled");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && empty_store |-> predicted_label == LABEL_OTHER
            && nearest_index == '0 && min_distance_sq == '0)
        else $error("empty-store result has non-default fields");

    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> predicted_label != 3'd0 && predicted_label != 3'd7)
        else $error("predicted label out of range");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && operation == OP_QUERY |=> !item_ready)
        else $error("ready after query transfer");

    a_update_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (operation == OP_CLEAR || operation == OP_LOAD)
            |=> item_ready)
        else $error("not ready after clear or load");

endmodule

bind nearest_neighbour_classifier_3d nnc3d_assertions u_nnc3d_assertions (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .operation       (operation),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .predicted_label (predicted_label),
    .nearest_index   (nearest_index),
    .min_distance_sq (min_distance_sq),
    .empty_store     (empty_store)
);

@@ tb/nnc3d_checker.sv @@
module nnc3d_checker #(
    parameter int STORE_DEPTH = nnc3d_pkg::STORE_DEPTH_DEF,
    parameter int CW          = nnc3d_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_ready,
    input  logic [nnc3d_pkg::OP_W-1:0]          operation,
    input  logic signed [CW-1:0]                coord_x,
    input  logic signed [CW-1:0]                coord_y,
    input  logic signed [CW-1:0]                coord_z,
    input  logic [nnc3d_pkg::LABEL_W-1:0]       train_label,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [nnc3d_pkg::LABEL_W-1:0]       predicted_label,
    input  logic [nnc3d_pkg::INDEX_W-1:0]       nearest_index,
    input  logic [nnc3d_pkg::DIST_OUT_W-1:0]    min_distance_sq,
    input  logic                                empty_store,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import nnc3d_pkg::*;

    typedef struct packed {
        logic [LABEL_W-1:0]    label;
        logic [INDEX_W-1:0]    index;
        logic [DIST_OUT_W-1:0] distance;
        logic                  empty;
    } nn_answer_t;

    logic signed [CW-1:0] point_x [STORE_DEPTH];
    logic signed [CW-1:0] point_y [STORE_DEPTH];
    logic signed [CW-1:0] point_z [STORE_DEPTH];
    logic [LABEL_W-1:0]   point_label [STORE_DEPTH];
    int                   point_count = 0;
    nn_answer_t           answer_q [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [DIST_OUT_W-1:0] dist_sq(
        input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
        input logic signed [CW-1:0] az, input logic signed [CW-1:0] bx,
        input logic signed [CW-1:0] by, input logic signed [CW-1:0] bz);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        dz = longint'(az) - longint'(bz);
        return DIST_OUT_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic nn_answer_t classify(input logic signed [CW-1:0] qx,
                                            input logic signed [CW-1:0] qy,
                                            input logic signed [CW-1:0] qz);
        nn_answer_t            a;
        logic [DIST_OUT_W-1:0] d;
        int                    best;
        if (point_count == 0)
        begin
            a.label    = LABEL_OTHER;
            a.index    = '0;
            a.distance = '0;
            a.empty    = 1'b1;
            return a;
        end
        best       = 0;
        a.distance = dist_sq(point_x[0], point_y[0], point_z[0], qx, qy, qz);
        for (int i = 1; i < point_count; i++)
        begin
            d = dist_sq(point_x[i], point_y[i], point_z[i], qx, qy, qz);
            if (d < a.distance)
            begin
                a.distance = d;
                best       = i;
            end
        end
        a.index = INDEX_W'(best);
        if (point_label[best] < LABEL_MIN || point_label[best] > LABEL_MAX)
            a.label = LABEL_OTHER;
        else
            a.label = point_label[best];
        a.empty = 1'b0;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        nn_answer_t want;
        if (!rst_n)
        begin
            point_count = 0;
            answer_q.delete();
            pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("unexpected result transfer: label %0d index %0d",
                           predicted_label, nearest_index);
                    fail_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (predicted_label !== want.label)
                    begin
                        $error("predicted_label: expected %0d, got %0d",
                               want.label, predicted_label);
                        fail_count++;
                    end
                    if (nearest_index !== want.index)
                    begin
                        $error("nearest_index: expected %0d, got %0d",
                               want.index, nearest_index);
                        fail_count++;
                    end
                    if (min_distance_sq !== want.distance)
                    begin
                        $error("min_distance_sq: expected %0d, got %0d",
                               want.distance, min_distance_sq);
                        fail_count++;
                    end
                    if (empty_store !== want.empty)
                    begin
                        $error("empty_store: expected %0d, got %0d",
                               want.empty, empty_store);
                        fail_count++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                case (operation)
                    OP_CLEAR:
                        point_count = 0;
                    OP_LOAD:
                        if (point_count < STORE_DEPTH)
                        begin
                            point_x[point_count]     = coord_x;
                            point_y[point_count]     = coord_y;
                            point_z[point_count]     = coord_z;
                            point_label[point_count] = train_label;
                            point_count++;
                        end
                    OP_QUERY:
                        answer_q.push_back(classify(coord_x, coord_y, coord_z));
                    default:
                        ;
                endcase
            end
            pending = answer_q.size();
        end
    end

endmodule

@@ tb/nearest_neighbour_classifier_3d_tb.sv @@
module nearest_neighbour_classifier_3d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnc3d_pkg::*;

    localparam int              CW               = COORD_BITS_DEF;
    localparam int              DEPTH            = STORE_DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED        = 2'd3;
    localparam int              LONG_HOLD_CYCLES = 3000;
    localparam int              RANDOM_ITEMS     = 340;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } point_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic [OP_W-1:0]       operation    = OP_CLEAR;
    logic signed [CW-1:0]  coord_x      = '0;
    logic signed [CW-1:0]  coord_y      = '0;
    logic signed [CW-1:0]  coord_z      = '0;
    logic [LABEL_W-1:0]    train_label  = '0;
    logic                  result_ready = 1'b0;
    logic                  item_ready;
    logic                  result_valid;
    logic [LABEL_W-1:0]    predicted_label;
    logic [INDEX_W-1:0]    nearest_index;
    logic [DIST_OUT_W-1:0] min_distance_sq;
    logic                  empty_store;

    int     fail_count;
    int     pending;
    int     items_sent = 0;
    bit     no_idle    = 1'b0;
    bit     long_hold  = 1'b0;
    point_t loaded_q [$];

    nearest_neighbour_classifier_3d dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .train_label     (train_label),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .predicted_label (predicted_label),
        .nearest_index   (nearest_index),
        .min_distance_sq (min_distance_sq),
        .empty_store     (empty_store)
    );

    nnc3d_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .train_label     (train_label),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .predicted_label (predicted_label),
        .nearest_index   (nearest_index),
        .min_distance_sq (min_distance_sq),
        .empty_store     (empty_store),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("nearest_neighbour_classifier_3d verification failed");
        $finish;
    end

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2, 3: return CW'($urandom);
            default: return CW'($urandom_range(0, 16)) - CW'(8);
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        return p;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input point_t p,
                             input logic [LABEL_W-1:0] lab);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        operation   <= op;
        coord_x     <= p.x;
        coord_y     <= p.y;
        coord_z     <= p.z;
        train_label <= lab;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
        if (op == OP_CLEAR)
            loaded_q.delete();
        else if (op == OP_LOAD && loaded_q.size() < DEPTH)
            loaded_q.push_back(p);
    endtask

    task automatic load_random();
        point_t p;
        if (loaded_q.size() > 0 && $urandom_range(0, 5) == 0)
            p = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        else
            p = rand_point();
        send_item(OP_LOAD, p, LABEL_W'($urandom_range(0, 7)));
    endtask

    task automatic query_random();
        point_t p;
        int     mode;
        mode = $urandom_range(0, 2);
        if (mode < 2 && loaded_q.size() > 0)
        begin
            p = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
            if (mode == 1)
            begin
                p.x = p.x + CW'($urandom_range(0, 6)) - CW'(3);
                p.y = p.y + CW'($urandom_range(0, 6)) - CW'(3);
                p.z = p.z + CW'($urandom_range(0, 6)) - CW'(3);
            end
        end
        else
            p = rand_point();
        send_item(OP_QUERY, p, LABEL_W'($urandom_range(0, 7)));
    endtask

    task automatic wait_drained();
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // result side: per-result stall, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, 15);
                if (gap > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    initial
    begin
        point_t pmin;
        point_t pmax;
        point_t pzero;
        point_t pmix;
        int     k;
        int     n;
        int     r;
        pmin  = '{COORD_MIN, COORD_MIN, COORD_MIN};
        pmax  = '{COORD_MAX, COORD_MAX, COORD_MAX};
        pzero = '{'0, '0, '0};
        pmix  = '{CW'(1), -CW'(1), CW'(2)};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, ties, unused code, clear
        send_item(OP_QUERY, rand_point(), '0);
        send_item(OP_UNUSED, rand_point(), 3'd7);
        send_item(OP_LOAD, pmin, 3'd0);
        send_item(OP_LOAD, pmax, 3'd7);
        send_item(OP_LOAD, pzero, 3'd1);
        send_item(OP_LOAD, pzero, 3'd5);
        send_item(OP_LOAD, pmix, 3'd3);
        send_item(OP_LOAD, rand_point(), 3'd4);
        send_item(OP_LOAD, rand_point(), 3'd2);
        send_item(OP_QUERY, pmax, '0);
        send_item(OP_QUERY, pmin, 3'd7);
        send_item(OP_QUERY, pzero, '0);
        send_item(OP_QUERY, pmix, '0);
        send_item(OP_UNUSED, pmin, 3'd0);
        send_item(OP_QUERY, rand_point(), '0);
        send_item(OP_CLEAR, pmax, 3'd7);
        send_item(OP_QUERY, pzero, '0);
        send_item(OP_LOAD, pmin, 3'd5);
        send_item(OP_QUERY, pmax, '0);
        send_item(OP_CLEAR, pzero, '0);

        wait_drained();

        // long receiver hold-off while queries keep coming
        long_hold = 1'b1;
        no_idle   = 1'b1;
        send_item(OP_CLEAR, rand_point(), '0);
        repeat (3) load_random();
        for (int i = 0; i < 6; i++)
        begin
            query_random();
            load_random();
        end
        no_idle = 1'b0;
        wait (!long_hold);
        wait_drained();

        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
                send_item(OP_CLEAR, rand_point(), LABEL_W'($urandom_range(0, 7)));
            no_idle = ($urandom_range(0, 4) == 0);
            k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            repeat (k) load_random();
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                r = $urandom_range(0, 19);
                if (r < 9)
                    query_random();
                else if (r < 17)
                    load_random();
                else if (r < 19)
                    send_item(OP_UNUSED, rand_point(), LABEL_W'($urandom_range(0, 7)));
                else
                    send_item(OP_CLEAR, rand_point(), LABEL_W'($urandom_range(0, 7)));
            end
        end
        no_idle = 1'b0;

        // full store, loads past the end are dropped
        send_item(OP_CLEAR, rand_point(), '0);
        repeat (DEPTH + 2) load_random();
        repeat (3) query_random();
        send_item(OP_QUERY, pmax, '0);
        send_item(OP_CLEAR, rand_point(), '0);
        send_item(OP_QUERY, rand_point(), '0);
        item_valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("nearest_neighbour_classifier_3d verification clean");
        else
            $display("nearest_neighbour_classifier_3d verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/nnc3d_pkg.sv
rtl/core/nearest_neighbour_classifier_3d.sv
rtl/core/nnc3d_checker.sv
tb/nnc3d_checker.sv
tb/nearest_neighbour_classifier_3d_tb.sv
